// ----- rtl/sidr_pkg.sv -----
// ----------------------------------------------------------------------------
// sidr_pkg
// Shared types and constants of the serial image download receiver.
// ----------------------------------------------------------------------------
package sidr_pkg;

    // Data bytes between two chunk acknowledgements.
    localparam int ACK_INTERVAL_DEF = 250;

    // Burst of results caused by one input item.
    localparam int BURST_MAX = 5;
    localparam int BURST_CW  = $clog2(BURST_MAX + 1);

    // Register map, by word index.
    localparam logic [2:0] REG_KERNEL_TYPE = 3'd0;
    localparam logic [2:0] REG_INITRD_TYPE = 3'd1;
    localparam logic [2:0] REG_KERNEL_BASE = 3'd2;
    localparam logic [2:0] REG_INITRD_BASE = 3'd3;
    localparam logic [2:0] REG_LOADER_LIM  = 3'd4;
    localparam int         APB_AW          = 5;

    localparam logic [31:0] LOADER_LIM_RST = 32'hFFFF_FFFF;

    // Link characters.
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_O   = 8'h4F;
    localparam logic [7:0] CH_K   = 8'h4B;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_R   = 8'h52;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_BOOT  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_TYPE2 = 4'd2,
        PH_TYPE3 = 4'd3,
        PH_SIZE0 = 4'd4,
        PH_SIZE1 = 4'd5,
        PH_SIZE2 = 4'd6,
        PH_SIZE3 = 4'd7,
        PH_DATA  = 4'd8,
        PH_HALT  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [31:0] kernel_type;
        logic [31:0] initrd_type;
        logic [31:0] kernel_base;
        logic [31:0] initrd_base;
        logic [31:0] loader_lim;
    } t_cfg;

    // Entry 0 has kind first_kind; every later entry is a transmit byte.
    typedef struct packed {
        logic [BURST_CW-1:0]          cnt;
        t_kind                        first_kind;
        logic [31:0]                  addr;
        logic [7:0]                   wdata;
        logic [BURST_MAX-1:0][7:0]    tx;
    } t_burst;

endpackage

// ----- rtl/serial_image_download_receiver_core.sv -----
// ----------------------------------------------------------------------------
// serial_image_download_receiver_core
// Boot image receiver over a byte link, with an APB register port.
// ----------------------------------------------------------------------------
// Input stream: s_tuser[0] = 1 asks for the start announcement, 0 carries a
// received link byte in s_tdata. Output stream: each transaction is one
// result; m_tuser gives its kind (transmit byte, memory write, boot request)
// and m_tlast marks the final result caused by one input item.
// The type codes, load bases and loader limit are written over APB while the
// block is idle; the user must keep to this, the block itself does not enforce it.
// An accepted item is held in an input register and is decoded when the
// result register is free or is handing out its final result. Its first
// result reaches the output through the input register and then the result
// register; a busy result register can hold it in between. Results leave at
// one per cycle while m_tready is high, and an item has zero to five results.
// Reset clears the protocol state and loads the register reset values; the
// block then waits for a start request. When the output is stalled the
// current result holds and one more input item is taken into the input
// register before s_tready drops.
// ----------------------------------------------------------------------------
module serial_image_download_receiver_core
    import sidr_pkg::*;
#(
    parameter int ACK_INTERVAL = ACK_INTERVAL_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    input  logic [0:0]        s_tuser,   // [0] cmd
    // Output stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // [7:0] tx_byte, [39:8] write_address,
                                         // [47:40] write_data
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register file.
    t_cfg       r_cfg;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_type <= '0;
            r_cfg.initrd_type <= '0;
            r_cfg.kernel_base <= '0;
            r_cfg.initrd_base <= '0;
            r_cfg.loader_lim  <= LOADER_LIM_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_KERNEL_TYPE: r_cfg.kernel_type <= pwdata;
                REG_INITRD_TYPE: r_cfg.initrd_type <= pwdata;
                REG_KERNEL_BASE: r_cfg.kernel_base <= pwdata;
                REG_INITRD_BASE: r_cfg.initrd_base <= pwdata;
                REG_LOADER_LIM:  r_cfg.loader_lim  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KERNEL_TYPE: prdata = r_cfg.kernel_type;
            REG_INITRD_TYPE: prdata = r_cfg.initrd_type;
            REG_KERNEL_BASE: prdata = r_cfg.kernel_base;
            REG_INITRD_BASE: prdata = r_cfg.initrd_base;
            REG_LOADER_LIM:  prdata = r_cfg.loader_lim;
            default:         prdata = '0;
        endcase
    end

    // Input register.
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_byte;

    // Result register.
    logic                r_busy;
    logic [BURST_CW-1:0] r_idx;
    t_burst              r_burst;
    t_burst              burst;

    logic out_fire;
    logic last_entry;
    logic consume;

    assign out_fire   = r_busy && m_tready;
    assign last_entry = (r_idx == r_burst.cnt - BURST_CW'(1));
    assign consume    = r_in_valid && (!r_busy || (out_fire && last_entry));
    assign s_tready   = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_cmd  <= s_tuser[0];
            r_in_byte <= s_tdata;
        end
    end

    sidr_ctrl #(
        .ACK_INTERVAL (ACK_INTERVAL)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (consume),
        .i_cmd   (r_in_cmd),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_burst (burst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (consume) begin
            r_busy <= (burst.cnt != '0);
            r_idx  <= '0;
        end else if (out_fire) begin
            if (last_entry) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + BURST_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_burst <= burst;
        end
    end

    // Entry 0 carries the burst's own kind; later entries are transmit bytes.
    t_kind      cur_kind;
    logic [7:0] cur_tx;
    logic       cur_write;

    always_comb begin
        cur_kind  = (r_idx == '0) ? r_burst.first_kind : KIND_TX;
        cur_write = (cur_kind == KIND_WRITE);
        cur_tx    = (cur_kind == KIND_TX) ? r_burst.tx[r_idx] : 8'd0;
    end

    assign m_tvalid = r_busy;
    assign m_tuser  = cur_kind;
    assign m_tlast  = last_entry;
    assign m_tdata  = {cur_write ? r_burst.wdata : 8'd0,
                       cur_write ? r_burst.addr : 32'd0,
                       cur_tx};

endmodule

// ----- rtl/sidr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sidr_ctrl
// Protocol state machine: header, type and size checks, data addressing and
// the result burst for each consumed input item.
// ----------------------------------------------------------------------------
module sidr_ctrl
    import sidr_pkg::*;
#(
    parameter int ACK_INTERVAL = ACK_INTERVAL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_cmd,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_burst     o_burst
);

    localparam int CW = $clog2(ACK_INTERVAL + 1);

    t_phase      r_phase, n_phase;
    logic        r_announced, n_announced;
    logic [31:0] r_header, n_header;
    logic        r_ramdisk, n_ramdisk;
    logic [31:0] r_size, n_size;
    logic [31:0] r_left, n_left;
    logic [31:0] r_addr, n_addr;
    logic [CW-1:0] r_chunk, n_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_announced <= 1'b0;
            r_header    <= '0;
            r_ramdisk   <= 1'b0;
            r_size      <= '0;
            r_left      <= '0;
            r_addr      <= '0;
            r_chunk     <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_announced <= n_announced;
            r_header    <= n_header;
            r_ramdisk   <= n_ramdisk;
            r_size      <= n_size;
            r_left      <= n_left;
            r_addr      <= n_addr;
            r_chunk     <= n_chunk;
        end
    end

    logic [31:0]   full_header;
    logic [31:0]   full_size;
    logic [31:0]   base;
    logic [31:0]   end_addr;
    logic [CW-1:0] chunk_inc;
    logic [31:0]   left_dec;

    always_comb begin
        full_header = {i_byte, r_header[23:0]};
        full_size   = {i_byte, r_size[23:0]};
        base        = r_ramdisk ? i_cfg.initrd_base : i_cfg.kernel_base;
        end_addr    = base + full_size;
        chunk_inc   = r_chunk + CW'(1);
        left_dec    = r_left - 32'd1;

        n_phase     = r_phase;
        n_announced = r_announced;
        n_header    = r_header;
        n_ramdisk   = r_ramdisk;
        n_size      = r_size;
        n_left      = r_left;
        n_addr      = r_addr;
        n_chunk     = r_chunk;

        o_burst            = '0;
        o_burst.first_kind = KIND_TX;

        if (r_phase != PH_HALT) begin
            if (i_cmd) begin
                if (!r_announced) begin
                    o_burst.cnt   = BURST_CW'(3);
                    o_burst.tx[0] = CH_ETX;
                    o_burst.tx[1] = CH_ETX;
                    o_burst.tx[2] = CH_ETX;
                    n_announced   = 1'b1;
                    n_phase       = PH_HDR0;
                end
            end else if (r_announced) begin
                case (r_phase)
                    PH_HDR0: begin
                        n_header = {24'd0, i_byte};
                        n_phase  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_header = {16'd0, i_byte, r_header[7:0]};
                        if (r_header[7:0] == CH_G && i_byte == CH_O) begin
                            o_burst.cnt        = BURST_CW'(1);
                            o_burst.first_kind = KIND_BOOT;
                            n_phase            = PH_HALT;
                        end else begin
                            n_phase = PH_TYPE2;
                        end
                    end
                    PH_TYPE2: begin
                        n_header = {8'd0, i_byte, r_header[15:0]};
                        n_phase  = PH_TYPE3;
                    end
                    PH_TYPE3: begin
                        n_header = full_header;
                        if (full_header != i_cfg.initrd_type &&
                            full_header != i_cfg.kernel_type) begin
                            o_burst.cnt   = BURST_CW'(5);
                            o_burst.tx[0] = CH_E;
                            o_burst.tx[1] = CH_R;
                            o_burst.tx[2] = CH_ETX;
                            o_burst.tx[3] = CH_ETX;
                            o_burst.tx[4] = CH_ETX;
                            n_phase       = PH_HDR0;
                        end else begin
                            // A type word that matches both codes is a ramdisk.
                            n_ramdisk     = (full_header == i_cfg.initrd_type);
                            o_burst.cnt   = BURST_CW'(2);
                            o_burst.tx[0] = CH_O;
                            o_burst.tx[1] = CH_K;
                            n_phase       = PH_SIZE0;
                        end
                    end
                    PH_SIZE0: begin
                        n_size  = {24'd0, i_byte};
                        n_phase = PH_SIZE1;
                    end
                    PH_SIZE1: begin
                        n_size  = {16'd0, i_byte, r_size[7:0]};
                        n_phase = PH_SIZE2;
                    end
                    PH_SIZE2: begin
                        n_size  = {8'd0, i_byte, r_size[15:0]};
                        n_phase = PH_SIZE3;
                    end
                    PH_SIZE3: begin
                        n_size = full_size;
                        if (end_addr > i_cfg.loader_lim) begin
                            o_burst.cnt   = BURST_CW'(5);
                            o_burst.tx[0] = CH_E;
                            o_burst.tx[1] = CH_R;
                            o_burst.tx[2] = CH_ETX;
                            o_burst.tx[3] = CH_ETX;
                            o_burst.tx[4] = CH_ETX;
                            n_phase       = PH_HDR0;
                        end else begin
                            n_left        = full_size;
                            n_addr        = base;
                            n_chunk       = '0;
                            o_burst.tx[0] = CH_O;
                            o_burst.tx[1] = CH_K;
                            if (full_size == 32'd0) begin
                                o_burst.cnt = BURST_CW'(2);
                                n_phase     = PH_HDR0;
                            end else begin
                                // The first chunk is acknowledged right away.
                                o_burst.cnt   = BURST_CW'(4);
                                o_burst.tx[2] = CH_O;
                                o_burst.tx[3] = CH_K;
                                n_phase       = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        o_burst.cnt        = BURST_CW'(1);
                        o_burst.first_kind = KIND_WRITE;
                        o_burst.addr       = r_addr;
                        o_burst.wdata      = i_byte;
                        n_addr             = r_addr + 32'd1;
                        n_left             = left_dec;
                        n_chunk            = (chunk_inc >= CW'(ACK_INTERVAL)) ? '0 : chunk_inc;
                        if (left_dec == 32'd0) begin
                            n_phase = PH_HDR0;
                        end else if (chunk_inc >= CW'(ACK_INTERVAL)) begin
                            o_burst.cnt   = BURST_CW'(3);
                            o_burst.tx[1] = CH_O;
                            o_burst.tx[2] = CH_K;
                        end
                    end
                    default: begin
                        n_phase = PH_HDR0;
                    end
                endcase
            end
        end
    end

endmodule
